// File: design/utf8_text_preview_normalizer_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the preview-text normalizer
// Shared macros for the concurrent checks; they expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef UTF8_TEXT_PREVIEW_NORMALIZER_CORE_DEFINES_SVH
`define UTF8_TEXT_PREVIEW_NORMALIZER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UTP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define UTP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/utp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utp_pkg
// Constants and types shared by the preview-text normalizer modules.
// ----------------------------------------------------------------------------
package utp_pkg;

	localparam logic [7:0] LEAD_BYTE   = 8'hE2;
	localparam logic [7:0] MID_PUNCT   = 8'h80;
	localparam logic [7:0] MID_LETTER  = 8'h84;
	localparam logic [7:0] SPACE_BYTE  = 8'h20;
	localparam logic [7:0] DEL_BYTE    = 8'h7F;
	localparam logic [7:0] APOS_BYTE   = 8'h27;
	localparam logic [7:0] QUOTE_BYTE  = 8'h22;

	// Largest number of result bytes one input byte can cause.
	localparam int unsigned UTP_MAX_RESULTS = 4;
	localparam int unsigned UTP_CNT_W       = $clog2(UTP_MAX_RESULTS + 1);

	// Default depth of the queue between front and back.
	localparam int unsigned UTP_QUEUE_DEPTH = 4;

	// One queue entry: the result bytes caused by one input byte.
	// A count of zero with last set is an empty end marker.
	typedef struct packed {
		logic [UTP_MAX_RESULTS-1:0][7:0] bytes;
		logic [UTP_CNT_W-1:0]            cnt;
		logic                            last;
	} utp_entry_t;

endpackage
`default_nettype wire

// File: design/utp_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utp_in_if
// Raw text byte channel with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface utp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       is_last;

	modport source (output valid, output in_byte, output is_last, input ready);
	modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface
`default_nettype wire

// File: design/utp_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utp_out_if
// Normalized byte channel with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface utp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_valid;
	logic       end_of_text;

	modport source (output valid, output out_byte, output out_valid, output end_of_text,
		input ready);
	modport sink   (input valid, input out_byte, input out_valid, input end_of_text,
		output ready);
endinterface
`default_nettype wire

// File: design/utf8_text_preview_normalizer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_text_preview_normalizer_core
// Cleans UTF-8 preview text: typographic quotes, dashes and spaces.
// ----------------------------------------------------------------------------
// Usage:
// The raw channel takes one text byte per beat, with is_last on the final
// byte of a text. The norm channel gives one result per beat: a cleaned byte
// with out_valid set, or, when the final byte of a text yields nothing, one empty
// marker with out_valid clear. end_of_text is set on the final result of a text.
// Curly quotes become ASCII quotes, dashes, ellipses and runs of whitespace
// or control bytes become one space, letterlike symbols are dropped, and
// the text never starts or ends with a space.
// Throughput: one input byte per cycle while the entry queue has room. Each
// byte that causes results takes one output beat per result (up to four),
// so the output register paces the block; bursts are absorbed by the queue.
// Path: an accepted byte is written into the queue, and its first result is
// then loaded from the queue head into the output register that drives norm.
// When the receiver stalls, the output holds its beat, the queue fills and
// raw.ready drops. Reset empties the queue and the output register and
// starts a fresh text.
// ----------------------------------------------------------------------------
module utf8_text_preview_normalizer_core import utp_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = UTP_QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	utp_in_if.sink    raw,
	utp_out_if.source norm
);

	// Front to queue: one entry per byte that yields results or ends a text.
	logic       push;
	utp_entry_t entry;
	logic       full;

	// Queue to back: the oldest entry, removed once fully sent.
	logic       not_empty;
	logic       pop;
	utp_entry_t head;

	// The front holds the sequence and space state and works at full rate while the queue has room.
	utp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw),
		.full   (full),
		.push   (push),
		.entry  (entry)
	);

	// The queue decouples the one-beat input from multi-beat results.
	utp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (entry),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head      (head)
	);

	// The back serializes each entry through the output register.
	utp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.norm      (norm)
	);

endmodule
`default_nettype wire

// File: design/utp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utp_front
// Accepts raw bytes, tracks held E2 sequences and space state, and builds
// one queue entry per byte that causes results or ends a text.
// ----------------------------------------------------------------------------
module utp_front import utp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	utp_in_if.sink     raw,
	input  wire logic  full,
	output logic       push,
	output utp_entry_t entry
);

	typedef struct packed {
		logic [UTP_MAX_RESULTS-1:0][7:0] bytes;
		logic [UTP_CNT_W-1:0]            cnt;
		logic                            mid_letter;
		logic [1:0]                      hcnt;
		logic                            sp;
		logic                            started;
	} work_t;

	logic       mid_letter_q;
	logic [1:0] hcnt_q;
	logic       sp_q;
	logic       started_q;
	work_t      w;
	logic       accept;

	function automatic work_t push_raw(work_t a, logic [7:0] b);
		work_t r;
		r = a;
		if (r.cnt < UTP_CNT_W'(UTP_MAX_RESULTS)) begin
			r.bytes[r.cnt[$clog2(UTP_MAX_RESULTS)-1:0]] = b;
			r.cnt = r.cnt + UTP_CNT_W'(1);
		end
		return r;
	endfunction

	function automatic work_t emit(work_t a, logic [7:0] b);
		work_t r;
		r = a;
		if (r.sp) begin
			r = push_raw(r, SPACE_BYTE);
			r.sp = 1'b0;
		end
		r = push_raw(r, b);
		r.started = 1'b1;
		return r;
	endfunction

	function automatic work_t collapse(work_t a);
		work_t r;
		r = a;
		if (r.started) begin
			r.sp = 1'b1;
		end
		return r;
	endfunction

	function automatic work_t feed_fresh(work_t a, logic [7:0] b);
		work_t r;
		r = a;
		if (b == LEAD_BYTE) begin
			r.hcnt = 2'd1;
		end else if (b <= SPACE_BYTE || b == DEL_BYTE) begin
			r = collapse(r);
		end else begin
			r = emit(r, b);
		end
		return r;
	endfunction

	always_comb begin
		w            = '0;
		w.mid_letter = mid_letter_q;
		w.hcnt       = 2'd0;
		w.sp         = sp_q;
		w.started    = started_q;
		case (hcnt_q)
			2'd1: begin
				if (raw.in_byte == MID_PUNCT || raw.in_byte == MID_LETTER) begin
					w.mid_letter = (raw.in_byte == MID_LETTER);
					w.hcnt       = 2'd2;
				end else begin
					w = emit(w, LEAD_BYTE);
					w = feed_fresh(w, raw.in_byte);
				end
			end
			2'd2: begin
				if (mid_letter_q) begin
					// Letterlike symbol: the whole sequence is dropped.
				end else if (raw.in_byte inside {8'h98, 8'h99, 8'h9B}) begin
					w = emit(w, APOS_BYTE);
				end else if (raw.in_byte inside {[8'h9C:8'h9F]}) begin
					w = emit(w, QUOTE_BYTE);
				end else if (raw.in_byte inside {[8'h90:8'h95], 8'hA6}) begin
					w = collapse(w);
				end else begin
					w = emit(w, LEAD_BYTE);
					w = emit(w, MID_PUNCT);
					w = feed_fresh(w, raw.in_byte);
				end
			end
			default: begin
				w = feed_fresh(w, raw.in_byte);
			end
		endcase
		if (raw.is_last) begin
			// An unfinished sequence at the end goes out literally.
			if (w.hcnt != 2'd0) begin
				w = emit(w, LEAD_BYTE);
			end
			if (w.hcnt == 2'd2) begin
				w = emit(w, w.mid_letter ? MID_LETTER : MID_PUNCT);
			end
		end
	end

	assign raw.ready   = !full;
	assign accept      = raw.valid && raw.ready;
	assign push        = accept && (w.cnt != '0 || raw.is_last);
	assign entry.bytes = w.bytes;
	assign entry.cnt   = w.cnt;
	assign entry.last  = raw.is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_letter_q <= 1'b0;
			hcnt_q       <= 2'd0;
			sp_q         <= 1'b0;
			started_q    <= 1'b0;
		end else if (accept) begin
			if (raw.is_last) begin
				mid_letter_q <= 1'b0;
				hcnt_q       <= 2'd0;
				sp_q         <= 1'b0;
				started_q    <= 1'b0;
			end else begin
				mid_letter_q <= w.mid_letter;
				hcnt_q       <= w.hcnt;
				sp_q         <= w.sp;
				started_q    <= w.started;
			end
		end
	end

endmodule
`default_nettype wire

// File: design/utp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utp_queue
// Small first-in first-out queue of entries between front and back.
// ----------------------------------------------------------------------------
module utp_queue import utp_pkg::*; #(
	parameter int unsigned DEPTH = UTP_QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire utp_entry_t wr_entry,
	input  wire logic       pop,
	output logic            full,
	output logic            not_empty,
	output utp_entry_t      head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	utp_entry_t       store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: design/utp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utp_back
// Walks the head entry one byte per beat into the output register.
// ----------------------------------------------------------------------------
module utp_back import utp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       not_empty,
	input  wire utp_entry_t head,
	output logic            pop,
	utp_out_if.source       norm
);

	localparam int unsigned SUB_W = $clog2(UTP_MAX_RESULTS);

	logic [SUB_W-1:0] sub_q;
	logic             valid_q;
	logic [7:0]       byte_q;
	logic             out_valid_q;
	logic             eot_q;
	logic             load;
	logic             is_final;

	assign load     = not_empty && (!valid_q || norm.ready);
	assign is_final = (head.cnt == '0) ||
		((UTP_CNT_W'(sub_q) + UTP_CNT_W'(1)) == head.cnt);
	assign pop      = load && is_final;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sub_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sub_q   <= is_final ? '0 : sub_q + SUB_W'(1);
			end else if (norm.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q      <= (head.cnt == '0) ? 8'h00 : head.bytes[sub_q];
			out_valid_q <= (head.cnt != '0);
			eot_q       <= head.last && is_final;
		end
	end

	assign norm.valid       = valid_q;
	assign norm.out_byte    = byte_q;
	assign norm.out_valid   = out_valid_q;
	assign norm.end_of_text = eot_q;

endmodule
`default_nettype wire

// File: design/utp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utp_checker
// Port-level checks on the normalized output of the preview-text block.
// ----------------------------------------------------------------------------
`include "utf8_text_preview_normalizer_core_defines.svh"

module utp_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       valid,
	input wire logic       ready,
	input wire logic [7:0] out_byte,
	input wire logic       out_valid,
	input wire logic       end_of_text
);

	logic       empty_beat;
	logic       carries_byte;
	logic       is_printable;
	logic       is_space;
	logic [9:0] beat;

	assign empty_beat   = valid && !out_valid;
	assign carries_byte = valid && out_valid;
	assign is_printable = (out_byte >= 8'h20) && (out_byte != 8'h7F);
	assign is_space     = (out_byte == 8'h20);
	assign beat         = {out_byte, out_valid, end_of_text};

	// A beat that carries no byte is only ever the empty end marker.
	`UTP_ASSERT_SAME(a_marker_form, empty_beat, end_of_text && out_byte == 8'h00, "bad end marker")

	// Whitespace and control bytes never leave the block as themselves.
	`UTP_ASSERT_SAME(a_no_ctrl, carries_byte, is_printable, "control byte on output")

	// A collapsed space is always followed by a byte, so it never ends a text.
	`UTP_ASSERT_SAME(a_no_trailing_space, carries_byte && is_space, !end_of_text, "text ends with a space")

	// A stalled beat holds.
	`UTP_ASSERT_NEXT(a_hold, valid && !ready, valid && $stable(beat), "stalled beat changed")

endmodule

bind utf8_text_preview_normalizer_core utp_checker u_utp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.valid       (norm.valid),
	.ready       (norm.ready),
	.out_byte    (norm.out_byte),
	.out_valid   (norm.out_valid),
	.end_of_text (norm.end_of_text)
);
`default_nettype wire
